@@ sv/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Constants and tables that the cartesian to spherical converter and its
// cells share.
// ----------------------------------------------------------------------------
`default_nettype none

package c2s_pkg;

   // width of the radius result
   localparam int RADIUS_W = 24;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX = {RADIUS_W{1'b1}};

   // cordic operands are scaled up by this many bits
   localparam int GUARD_SHIFT = 24;

   // angle accumulator, in units of 2^-32 turn, signed with headroom
   localparam int ACC_W = 34;
   localparam int TURN_W = 32;
   localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [TURN_W-1:0] HALF_TURN    = 32'h8000_0000;

   // atan(2^-i) in units of 2^-32 turn
   localparam int TABLE_LEN = 24;
   localparam logic [TURN_W-1:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

endpackage

`default_nettype wire

@@ sv/c2s_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// c2s_sqrt_cell
// One digit of a restoring square root on two lanes, with a registered
// handover to the next cell and a sideband that rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_sqrt_cell #(
   parameter int RW  = 24,
   parameter int SBW = 76
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [1:0][2*RW-1:0]       in_n,
   input  logic [1:0][RW+1:0]         in_rem,
   input  logic [1:0][RW-1:0]         in_root,
   input  logic [SBW-1:0]             in_sb,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [1:0][2*RW-1:0]       out_n,
   output logic [1:0][RW+1:0]         out_rem,
   output logic [1:0][RW-1:0]         out_root,
   output logic [SBW-1:0]             out_sb
);

   logic                   valid_ff;
   logic [1:0][2*RW-1:0]   n_ff, n_in;
   logic [1:0][RW+1:0]     rem_ff, rem_in;
   logic [1:0][RW-1:0]     root_ff, root_in;
   logic [SBW-1:0]         sb_ff;

   // one root digit per lane
   always_comb begin
      logic [RW+3:0] shifted;
      logic [RW+3:0] trial;
      logic [RW+3:0] diff;
      for (int l = 0; l < 2; l++) begin
         shifted = {in_rem[l], in_n[l][2*RW-1:2*RW-2]};
         trial   = {2'b00, in_root[l], 2'b01};
         diff    = shifted - trial;
         n_in[l] = {in_n[l][2*RW-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in[l]  = diff[RW+1:0];
            root_in[l] = {in_root[l][RW-2:0], 1'b1};
         end else begin
            rem_in[l]  = shifted[RW+1:0];
            root_in[l] = {in_root[l][RW-2:0], 1'b0};
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // handover register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         n_ff    <= n_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sb_ff   <= in_sb;
      end
   end

   assign out_valid = valid_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_sb    = sb_ff;

endmodule

`default_nettype wire

@@ sv/c2s_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// c2s_cordic_cell
// One vectoring cordic rotation on two lanes, with a registered handover to
// the next cell and a sideband that rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_cordic_cell #(
   parameter int XW   = 51,
   parameter int STEP = 0,
   parameter int SBW  = 33
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [1:0][XW-1:0]         in_x,
   input  logic signed [1:0][XW-1:0]         in_y,
   input  logic signed [1:0][c2s_pkg::ACC_W-1:0] in_acc,
   input  logic [SBW-1:0]                    in_sb,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [1:0][XW-1:0]         out_x,
   output logic signed [1:0][XW-1:0]         out_y,
   output logic signed [1:0][c2s_pkg::ACC_W-1:0] out_acc,
   output logic [SBW-1:0]                    out_sb
);
   import c2s_pkg::*;

   localparam logic [ACC_W-1:0] STEP_ANGLE = {2'b00, ATAN_TURNS[STEP]};

   logic                          valid_ff;
   logic [1:0][XW-1:0]            x_ff, x_in, y_ff, y_in;
   logic [1:0][ACC_W-1:0]         acc_ff, acc_in;
   logic [SBW-1:0]                sb_ff;

   // rotate towards the x axis, floor shifts
   always_comb begin
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      for (int l = 0; l < 2; l++) begin
         dx = $signed(in_y[l]) >>> STEP;
         dy = $signed(in_x[l]) >>> STEP;
         if (!in_y[l][XW-1]) begin
            x_in[l]   = in_x[l] + dx;
            y_in[l]   = in_y[l] - dy;
            acc_in[l] = in_acc[l] + STEP_ANGLE;
         end else begin
            x_in[l]   = in_x[l] - dx;
            y_in[l]   = in_y[l] + dy;
            acc_in[l] = in_acc[l] - STEP_ANGLE;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // handover register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         acc_ff <= acc_in;
         sb_ff  <= in_sb;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;
   assign out_sb    = sb_ff;

endmodule

`default_nettype wire

@@ sv/cartesian_to_spherical.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical
// Converts one lidar point per clock, unless the result channel stalls, to radius, azimuth and polar angle.
// ----------------------------------------------------------------------------
// Usage
//   request channel: req_x_mm, req_y_mm, req_z_mm, req_last_in with
//   req_valid / req_ready. Result channel: rsp_radius_mm, rsp_azimuth,
//   rsp_polar, rsp_undefined_direction, rsp_last_out with rsp_valid /
//   rsp_ready.
//   One request is taken per clock while the pipeline is not stalled. The
//   pipeline runs through stages a, b and c for magnitude, square and sum,
//   one square root cell per result bit, one rounding stage, one cordic cell
//   per rotation and the output register.
//   Every stage has its own valid flag and takes new data when it is empty or
//   its successor moves, so bubbles close up and a stalled receiver only
//   backs up the pipeline once all stages hold a point.
//   Angles are fractions of a full turn, 2^ANGLE_WIDTH units per turn. The
//   origin raises rsp_undefined_direction with both angles zero.
//   Reset (synchronous) empties all stages; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_spherical #(
   parameter int COORD_WIDTH  = 24,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_WIDTH-1:0]  req_x_mm,
   input  logic signed [COORD_WIDTH-1:0]  req_y_mm,
   input  logic signed [COORD_WIDTH-1:0]  req_z_mm,
   input  logic                           req_last_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [c2s_pkg::RADIUS_W-1:0]   rsp_radius_mm,
   output logic [ANGLE_WIDTH-1:0]         rsp_azimuth,
   output logic [ANGLE_WIDTH-1:0]         rsp_polar,
   output logic                           rsp_undefined_direction,
   output logic                           rsp_last_out
);
   import c2s_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int SW   = 2 * CW;
   localparam int XW   = CW + GUARD_SHIFT + 3;
   localparam int SQB  = 3 * CW + 4;
   localparam int CSB  = RADIUS_W + 9;

   // ---------------- stage a: magnitudes and signs
   logic            a_valid_ff, a_ready;
   logic [CW-1:0]   a_x_ff, a_y_ff, a_z_ff;
   logic            a_nx_ff, a_ny_ff, a_nz_ff, a_last_ff;
   logic            b_ready;

   assign a_ready   = !a_valid_ff || b_ready;
   assign req_ready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= req_valid;
      end
      if (a_ready && req_valid) begin
         a_x_ff    <= req_x_mm[CW-1] ? CW'(-req_x_mm) : req_x_mm;
         a_y_ff    <= req_y_mm[CW-1] ? CW'(-req_y_mm) : req_y_mm;
         a_z_ff    <= req_z_mm[CW-1] ? CW'(-req_z_mm) : req_z_mm;
         a_nx_ff   <= req_x_mm[CW-1];
         a_ny_ff   <= req_y_mm[CW-1];
         a_nz_ff   <= req_z_mm[CW-1];
         a_last_ff <= req_last_in;
      end
   end

   // ---------------- stage b: squares
   logic            b_valid_ff, c_ready;
   logic [SW-1:0]   b_sx_ff, b_sy_ff, b_sz_ff;
   logic [SQB-1:0]  b_sb_ff;

   assign b_ready = !b_valid_ff || c_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if (b_ready && a_valid_ff) begin
         b_sx_ff <= a_x_ff * a_x_ff;
         b_sy_ff <= a_y_ff * a_y_ff;
         b_sz_ff <= a_z_ff * a_z_ff;
         b_sb_ff <= {a_x_ff, a_y_ff, a_z_ff, a_nx_ff, a_ny_ff, a_nz_ff, a_last_ff};
      end
   end

   // ---------------- stage c: sums of squares
   logic                c_valid_ff;
   logic [1:0][SW-1:0]  c_n_ff;
   logic [SQB-1:0]      c_sb_ff;
   logic [CW:0]         sq_valid, sq_ready;

   assign c_ready = !c_valid_ff || sq_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_ready) begin
         c_valid_ff <= b_valid_ff;
      end
      if (c_ready && b_valid_ff) begin
         c_n_ff[0] <= b_sx_ff + b_sy_ff;
         c_n_ff[1] <= b_sx_ff + b_sy_ff + b_sz_ff;
         c_sb_ff   <= b_sb_ff;
      end
   end

   // ---------------- square root cells, one per result bit
   logic [CW:0][1:0][SW-1:0]  sq_n;
   logic [CW:0][1:0][CW+1:0]  sq_rem;
   logic [CW:0][1:0][CW-1:0]  sq_root;
   logic [CW:0][SQB-1:0]      sq_sb;
   logic                      r_ready;

   assign sq_valid[0] = c_valid_ff;
   assign sq_n[0]     = c_n_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_sb[0]    = c_sb_ff;
   assign sq_ready[CW] = r_ready;

   for (genvar k = 0; k < CW; k++) begin : g_sqrt
      c2s_sqrt_cell #(.RW(CW), .SBW(SQB)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_n      (sq_n[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .in_sb     (sq_sb[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_n     (sq_n[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1]),
         .out_sb    (sq_sb[k+1])
      );
   end

   // ---------------- stage r: round roots, load cordic lanes
   logic [CW-1:0]   r_ax, r_ay, r_az;
   logic            r_nx, r_ny, r_nz, r_last;
   logic [CW:0]     rho_rnd, rad_rnd;
   logic [RADIUS_W-1:0] rad_sat;

   assign {r_ax, r_ay, r_az, r_nx, r_ny, r_nz, r_last} = sq_sb[CW];
   assign rho_rnd = {1'b0, sq_root[CW][0]}
                    + (CW+1)'((sq_rem[CW][0] > {2'b00, sq_root[CW][0]}) ? 1 : 0);
   assign rad_rnd = {1'b0, sq_root[CW][1]}
                    + (CW+1)'((sq_rem[CW][1] > {2'b00, sq_root[CW][1]}) ? 1 : 0);

   // radius saturates only when the coordinates are wider than the result
   always_comb begin
      if (rad_rnd > (CW+1)'(RADIUS_MAX)) begin
         rad_sat = RADIUS_MAX;
      end else begin
         rad_sat = RADIUS_W'(rad_rnd);
      end
   end

   logic                         r_valid_ff;
   logic [1:0][XW-1:0]           r_x_ff, r_y_ff;
   logic [CSB-1:0]               r_sb_ff;
   logic [CORDIC_STEPS:0]        co_valid, co_ready;

   assign r_ready = !r_valid_ff || co_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (r_ready) begin
         r_valid_ff <= sq_valid[CW];
      end
      if (r_ready && sq_valid[CW]) begin
         r_x_ff[0] <= {3'b000, r_ax, {GUARD_SHIFT{1'b0}}};
         r_y_ff[0] <= {3'b000, r_ay, {GUARD_SHIFT{1'b0}}};
         r_x_ff[1] <= {3'b000, r_az, {GUARD_SHIFT{1'b0}}};
         r_y_ff[1] <= {3'b000, rho_rnd[CW-1:0], {GUARD_SHIFT{1'b0}}};
         r_sb_ff   <= {rad_sat, r_nx, r_ny, r_nz, r_last,
                       (r_ax == '0) && (r_ay == '0) && (r_az == '0),
                       r_ay == '0, r_ax == '0,
                       rho_rnd == '0, r_az == '0};
      end
   end

   // ---------------- cordic cells, one per rotation
   logic [CORDIC_STEPS:0][1:0][XW-1:0]     co_x, co_y;
   logic [CORDIC_STEPS:0][1:0][ACC_W-1:0]  co_acc;
   logic [CORDIC_STEPS:0][CSB-1:0]         co_sb;
   logic                                   o_ready;

   assign co_valid[0] = r_valid_ff;
   assign co_x[0]     = r_x_ff;
   assign co_y[0]     = r_y_ff;
   assign co_acc[0]   = '0;
   assign co_sb[0]    = r_sb_ff;
   assign co_ready[CORDIC_STEPS] = o_ready;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      c2s_cordic_cell #(.XW(XW), .STEP(i), .SBW(CSB)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (co_valid[i]),
         .in_ready  (co_ready[i]),
         .in_x      (co_x[i]),
         .in_y      (co_y[i]),
         .in_acc    (co_acc[i]),
         .in_sb     (co_sb[i]),
         .out_valid (co_valid[i+1]),
         .out_ready (co_ready[i+1]),
         .out_x     (co_x[i+1]),
         .out_y     (co_y[i+1]),
         .out_acc   (co_acc[i+1]),
         .out_sb    (co_sb[i+1])
      );
   end

   // ---------------- stage o: quadrant map and rounding
   logic [RADIUS_W-1:0]  o_rad;
   logic                 o_nx, o_ny, o_nz, o_last, o_origin;
   logic                 az_b0, az_a0, po_b0, po_a0;
   logic [TURN_W-1:0]    az_q, po_q, az_turn, po_turn;

   assign {o_rad, o_nx, o_ny, o_nz, o_last, o_origin,
           az_b0, az_a0, po_b0, po_a0} = co_sb[CORDIC_STEPS];

   function automatic logic [TURN_W-1:0] clamp_q(input logic [ACC_W-1:0] acc,
                                                 input logic b_zero,
                                                 input logic a_zero);
      logic [TURN_W-1:0] r;
      if (b_zero) begin
         r = '0;
      end else if (a_zero) begin
         r = QUARTER_TURN;
      end else if (acc[ACC_W-1]) begin
         r = '0;
      end else if (acc > {2'b00, QUARTER_TURN}) begin
         r = QUARTER_TURN;
      end else begin
         r = acc[TURN_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [ANGLE_WIDTH-1:0] round_turn(input logic [TURN_W-1:0] t);
      logic [TURN_W:0] s;
      s = {1'b0, t} + ((TURN_W+1)'(1) << (TURN_W - 1 - ANGLE_WIDTH));
      return s[TURN_W-1 -: ANGLE_WIDTH];
   endfunction

   assign az_q = clamp_q(co_acc[CORDIC_STEPS][0], az_b0, az_a0);
   assign po_q = clamp_q(co_acc[CORDIC_STEPS][1], po_b0, po_a0);

   // azimuth quadrant and polar half, all modulo a full turn
   always_comb begin
      case ({o_nx, o_ny})
         2'b00:   az_turn = az_q;
         2'b10:   az_turn = HALF_TURN - az_q;
         2'b11:   az_turn = HALF_TURN + az_q;
         default: az_turn = TURN_W'(0) - az_q;
      endcase
      po_turn = o_nz ? HALF_TURN - po_q : po_q;
   end

   logic                    o_valid_ff;
   logic [RADIUS_W-1:0]     o_rad_ff;
   logic [ANGLE_WIDTH-1:0]  o_az_ff, o_po_ff;
   logic                    o_undef_ff, o_last_ff;

   assign o_ready = !o_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= co_valid[CORDIC_STEPS];
      end
      if (o_ready && co_valid[CORDIC_STEPS]) begin
         o_rad_ff   <= o_rad;
         o_az_ff    <= o_origin ? '0 : round_turn(az_turn);
         o_po_ff    <= o_origin ? '0 : round_turn(po_turn);
         o_undef_ff <= o_origin;
         o_last_ff  <= o_last;
      end
   end

   assign rsp_valid               = o_valid_ff;
   assign rsp_radius_mm           = o_rad_ff;
   assign rsp_azimuth             = o_az_ff;
   assign rsp_polar               = o_po_ff;
   assign rsp_undefined_direction = o_undef_ff;
   assign rsp_last_out            = o_last_ff;

endmodule

`default_nettype wire

@@ sv/c2s_checker.sv @@
// ----------------------------------------------------------------------------
// c2s_checker
// Port level checks for the cartesian to spherical converter, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module c2s_checker #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [c2s_pkg::RADIUS_W-1:0]  rsp_radius_mm,
   input  logic [ANGLE_WIDTH-1:0]        rsp_azimuth,
   input  logic [ANGLE_WIDTH-1:0]        rsp_polar,
   input  logic                          rsp_undefined_direction
);
   import c2s_pkg::*;

   localparam logic [ANGLE_WIDTH-1:0] HALF = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

   // origin carries no direction and no distance
   a_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined_direction |->
         rsp_azimuth == '0 && rsp_polar == '0 && rsp_radius_mm == '0)
      else $error("origin result not zero");

   // a nonzero point has a nonzero radius
   a_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_undefined_direction |-> rsp_radius_mm != '0)
      else $error("zero radius on a defined direction");

   // polar angle spans half a turn at most
   a_polar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_polar <= HALF)
      else $error("polar angle beyond half a turn");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_radius_mm)
         && $stable(rsp_azimuth) && $stable(rsp_polar))
      else $error("stalled result changed");

endmodule

bind cartesian_to_spherical c2s_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_c2s_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_valid),
   .rsp_ready               (rsp_ready),
   .rsp_radius_mm           (rsp_radius_mm),
   .rsp_azimuth             (rsp_azimuth),
   .rsp_polar               (rsp_polar),
   .rsp_undefined_direction (rsp_undefined_direction)
);

`default_nettype wire

@@ tb/sv/tb_cartesian_to_spherical.sv @@
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical
// Self-checking bench for the cartesian to spherical converter. Requests are
// driven with random idling on both sides; each result is predicted by an
// independent integer square root and vectoring cordic model and compared
// field by field, in order, against the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cartesian_to_spherical;
   import c2s_pkg::*;

   localparam int CW = 24;
   localparam int AW = 16;
   localparam int STEPS = 16;
   localparam int LATENCY = CW + STEPS + 5;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [23:0] radius;
      logic [15:0] azimuth;
      logic [15:0] polar;
      logic        undef_dir;
      logic        last;
   } sph_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [CW-1:0] req_x_mm = '0, req_y_mm = '0, req_z_mm = '0;
   logic req_last_in = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [23:0] rsp_radius_mm;
   logic [15:0] rsp_azimuth, rsp_polar;
   logic rsp_undefined_direction, rsp_last_out;

   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_stall = 0;
   int hold_off = 0;

   always #2 clock = ~clock;

   cartesian_to_spherical dut (.*);

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // rounded integer square root, exact half rounds up
   function automatic longint unsigned round_sqrt(input longint unsigned n);
      longint unsigned root, bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= root + bit_v) begin
            n -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      if (n > root) root++;
      return root;
   endfunction

   // first-quadrant vectoring cordic, result in 2^-32 turn
   function automatic logic [31:0] vector_angle(input longint unsigned a, input longint unsigned b);
      longint signed vx, vy, acc, dx, dy;
      if (b == 0) return 32'd0;
      if (a == 0) return QUARTER_TURN;
      vx = longint'(a << GUARD_SHIFT);
      vy = longint'(b << GUARD_SHIFT);
      acc = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx += dx; vy -= dy; acc += longint'(ATAN_TURNS[i]);
         end else begin
            vx -= dx; vy += dy; acc -= longint'(ATAN_TURNS[i]);
         end
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(QUARTER_TURN)) acc = longint'(QUARTER_TURN);
      return acc[31:0];
   endfunction

   function automatic logic [15:0] to_angle(input logic [31:0] turns);
      logic [32:0] t;
      t = {1'b0, turns} + (33'd1 << (31 - AW));
      return t[31:32-AW];
   endfunction

   function automatic sph_type convert_point(input logic signed [CW-1:0] x,
         input logic signed [CW-1:0] y, input logic signed [CW-1:0] z, input logic last);
      sph_type r;
      longint unsigned ax, ay, az, rad, rho;
      logic [31:0] a, azim, pol;
      ax = x < 0 ? longint'(-longint'(x)) : longint'(x);
      ay = y < 0 ? longint'(-longint'(y)) : longint'(y);
      az = z < 0 ? longint'(-longint'(z)) : longint'(z);
      rad = round_sqrt(ax*ax + ay*ay + az*az);
      if (rad > 64'hFFFFFF) rad = 64'hFFFFFF;
      rho = round_sqrt(ax*ax + ay*ay);
      a = vector_angle(ax, ay);
      if (x >= 0 && y >= 0) azim = a;
      else if (x < 0 && y >= 0) azim = HALF_TURN - a;
      else if (x < 0) azim = HALF_TURN + a;
      else azim = 32'd0 - a;
      a = vector_angle(az, rho);
      pol = z < 0 ? HALF_TURN - a : a;
      r.radius = rad[23:0];
      r.last = last;
      if (ax == 0 && ay == 0 && az == 0) begin
         r.azimuth = '0; r.polar = '0; r.undef_dir = 1'b1;
      end else begin
         r.azimuth = to_angle(azim); r.polar = to_angle(pol); r.undef_dir = 1'b0;
      end
      return r;
   endfunction

   class point_scoreboard_type;
      sph_type pending[$];
      int checked = 0;

      function void note_request(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
            input logic signed [CW-1:0] z, input logic last);
         pending.insert(pending.size(), convert_point(x, y, z, last));
      endfunction

      task check_result(input sph_type got);
         sph_type want;
         if (pending.size() == 0) begin
            $display("unexpected result at cycle %0d", cycles);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.radius != want.radius) report("radius", got.radius, want.radius);
         if (got.azimuth != want.azimuth) report("azimuth", got.azimuth, want.azimuth);
         if (got.polar != want.polar) report("polar", got.polar, want.polar);
         if (got.undef_dir != want.undef_dir) report("undefined", got.undef_dir, want.undef_dir);
         if (got.last != want.last) report("last", got.last, want.last);
      endtask
   endclass

   point_scoreboard_type sb = new();

   // monitor both channels at the clock edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready)
         sb.note_request(req_x_mm, req_y_mm, req_z_mm, req_last_in);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result({rsp_radius_mm, rsp_azimuth, rsp_polar,
                          rsp_undefined_direction, rsp_last_out});
   end

   // receiver: random stalls, plus a long hold-off counted here
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycles);
         $display("cartesian_to_spherical verification failed");
         $finish;
      end
   end

   // drive one request and wait for its acceptance
   task automatic send_point(input int x, input int y, input int z, input int last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_mm <= CW'(x); req_y_mm <= CW'(y); req_z_mm <= CW'(z);
      req_last_in <= (last != 0);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic int rand_coord();
      case ($urandom_range(5))
         0: return int'($urandom_range(15)) - 8;
         1: return int'($urandom_range(2047)) - 1024;
         2: return ($urandom_range(1) != 0) ? 8388607 : -8388608;
         3: return 0;
         default: return int'($urandom_range(16777215)) - 8388608;
      endcase
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   int recv_set[4] = '{0, 0, 69, 37};
   int send_set[4] = '{0, 69, 0, 37};

   initial begin
      int mx, mn;
      mx = 8388607;
      mn = -8388608;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: origin, axes, extremes, quadrant boundaries
      send_point(0, 0, 0, 1);
      send_point(5, 0, 0, 0);
      send_point(-5, 0, 0, 0);
      send_point(0, 7, 0, 0);
      send_point(0, -7, 0, 0);
      send_point(0, 0, 9, 0);
      send_point(0, 0, -9, 1);
      send_point(mx, mx, mx, 0);
      send_point(mn, mn, mn, 1);
      send_point(mn, mx, mn, 0);
      send_point(mx, mn, mx, 0);
      send_point(mx, -1, 0, 0);
      send_point(1, -1, 1, 0);
      send_point(-1, -1, -1, 0);
      send_point(-1, 1, 0, 0);
      send_point(3, 4, 0, 0);
      send_point(1, 1, 0, 1);
      send_point(mn, 0, 0, 0);
      send_point(0, 0, mn, 0);
      send_point(5592405, -2796202, 986895, 1);
      drain();

      // random phases with different idling
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = send_set[ph];
         recv_stall = recv_set[ph];
         for (int i = 0; i < 450; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), int'($urandom_range(1)));
         drain();
      end

      // long receiver hold-off while requests keep coming
      send_idle = 0;
      recv_stall = 0;
      hold_off = 3 * LATENCY;
      for (int i = 0; i < 200; i++)
         send_point(rand_coord(), rand_coord(), rand_coord(), int'($urandom_range(1)));
      drain();
      repeat (LATENCY + 5) @(posedge clock);

      $display("checked %0d points in four idling phases and a backpressure burst",
               sb.checked);
      $display("covered origin, axes, all quadrants and full-scale coordinates");
      if (errors == 0 && sb.pending.size() == 0)
         $display("cartesian_to_spherical verification clean");
      else
         $display("cartesian_to_spherical verification failed");
      $finish;
   end

endmodule
